/* sv/websocket_frame_deframer_top_assert.svh */
// Assertion macros for the frame deframer.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define WFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define WFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/wfd_pkg.sv */
package wfd_pkg;

    localparam int LENGTH_BITS = 64;
    localparam logic [63:0] LEN_MAX = ~64'd0 >> (64 - LENGTH_BITS);

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;
    localparam logic [3:0] KEY_BYTES = 4'd4;

    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_DATA = 5'b10000
    } t_phase;

    // Clamp a decoded length to the supported length width.
    function automatic logic [63:0] sat_len(input logic [63:0] len);
        return (len > LEN_MAX) ? LEN_MAX : len;
    endfunction

endpackage

/* sv/websocket_frame_deframer_top.sv */
// A payload byte or empty-frame marker is registered in the output when its byte is taken.
// Throughput: a byte per cycle unless stalled; phase update and key XOR are combinational.
// Header, length and key bytes produce no result but the empty-frame marker; a full
// output register that is stalled holds off the input until it is taken.
// Reset (synchronous, active low) returns the parser to the first header byte.
module websocket_frame_deframer_top
    import wfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [7:0]  o_payload_byte,
    output logic [3:0]  o_frame_opcode,
    output logic        o_final_fragment,
    output logic        o_was_masked,
    output logic [63:0] o_frame_length,
    output logic        o_first_of_frame,
    output logic        o_last_of_frame,
    output logic        o_empty_frame
);

`include "websocket_frame_deframer_top_assert.svh"

    t_phase      r_phase, n_phase;
    logic [3:0]  r_cnt, n_cnt;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_fin, n_fin;
    logic        r_masked, n_masked;
    logic [63:0] r_len, n_len;
    logic [63:0] r_rem, n_rem;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_kidx, n_kidx;

    logic        r_out_valid;
    logic [7:0]  r_payload;
    logic [3:0]  r_out_opcode;
    logic        r_out_fin;
    logic        r_out_masked;
    logic [63:0] r_out_len;
    logic        r_out_first;
    logic        r_out_last;
    logic        r_out_empty;

    logic        rx_take;
    logic        res_emit;
    logic [7:0]  res_data;
    logic        res_first;
    logic        res_last;
    logic        res_empty;
    logic [7:0]  key_byte;
    logic [6:0]  len_code;
    logic [63:0] len_shift;
    logic [3:0]  cnt_dec;

    assign o_rx_stall = r_out_valid && i_res_stall;
    assign rx_take    = i_rx_valid && !o_rx_stall;

    assign key_byte  = r_key[{~r_kidx, 3'b000} +: 8];
    assign len_code  = i_rx_byte[6:0];
    assign len_shift = {r_len[55:0], i_rx_byte};
    assign cnt_dec   = r_cnt - 4'd1;

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_opcode  = r_opcode;
        n_fin     = r_fin;
        n_masked  = r_masked;
        n_len     = r_len;
        n_rem     = r_rem;
        n_key     = r_key;
        n_kidx    = r_kidx;
        res_emit  = 1'b0;
        res_data  = 8'd0;
        res_first = 1'b0;
        res_last  = 1'b0;
        res_empty = 1'b0;
        case (r_phase)
            PH_HDR0: begin
                n_fin    = i_rx_byte[7];
                n_opcode = i_rx_byte[3:0];
                n_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                n_masked = i_rx_byte[7];
                if (len_code inside {LEN_CODE_16, LEN_CODE_64}) begin
                    n_len   = 64'd0;
                    n_cnt   = (len_code == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
                    n_phase = PH_EXT;
                end else begin
                    n_len = sat_len({57'd0, len_code});
                    n_key = 32'd0;
                    if (i_rx_byte[7]) begin
                        n_cnt   = KEY_BYTES;
                        n_phase = PH_KEY;
                    end else begin
                        n_rem  = n_len;
                        n_kidx = 2'd0;
                        if (n_len == 64'd0) begin
                            res_emit = 1'b1;
                            n_phase  = PH_HDR0;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
            end
            PH_EXT: begin
                n_len = len_shift;
                n_cnt = cnt_dec;
                if (cnt_dec == 4'd0) begin
                    n_len = sat_len(len_shift);
                    n_key = 32'd0;
                    if (r_masked) begin
                        n_cnt   = KEY_BYTES;
                        n_phase = PH_KEY;
                    end else begin
                        n_rem  = n_len;
                        n_kidx = 2'd0;
                        if (n_len == 64'd0) begin
                            res_emit = 1'b1;
                            n_phase  = PH_HDR0;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
            end
            PH_KEY: begin
                n_key = {r_key[23:0], i_rx_byte};
                n_cnt = cnt_dec;
                if (cnt_dec == 4'd0) begin
                    n_rem  = r_len;
                    n_kidx = 2'd0;
                    if (r_len == 64'd0) begin
                        res_emit = 1'b1;
                        n_phase  = PH_HDR0;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                res_emit  = 1'b1;
                res_data  = i_rx_byte ^ key_byte;
                res_first = (r_rem == r_len);
                res_last  = (r_rem[63:1] == 63'd0);
                n_kidx    = r_kidx + 2'd1;
                if (r_rem != 64'd0) begin
                    n_rem = r_rem - 64'd1;
                end
                if (res_last) begin
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                n_phase = PH_HDR0;
            end
        endcase
        // The empty-frame marker is the only result a header byte can produce.
        if (res_emit && (r_phase != PH_DATA)) begin
            res_first = 1'b1;
            res_last  = 1'b1;
            res_empty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_cnt    <= 4'd0;
            r_opcode <= 4'd0;
            r_fin    <= 1'b0;
            r_masked <= 1'b0;
            r_len    <= 64'd0;
            r_rem    <= 64'd0;
            r_key    <= 32'd0;
            r_kidx   <= 2'd0;
        end else if (rx_take) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_opcode <= n_opcode;
            r_fin    <= n_fin;
            r_masked <= n_masked;
            r_len    <= n_len;
            r_rem    <= n_rem;
            r_key    <= n_key;
            r_kidx   <= n_kidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rx_take) begin
            r_out_valid <= res_emit;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_take && res_emit) begin
            r_payload    <= res_data;
            r_out_opcode <= n_opcode;
            r_out_fin    <= n_fin;
            r_out_masked <= n_masked;
            r_out_len    <= n_len;
            r_out_first  <= res_first;
            r_out_last   <= res_last;
            r_out_empty  <= res_empty;
        end
    end

    assign o_res_valid      = r_out_valid;
    assign o_payload_byte   = r_payload;
    assign o_frame_opcode   = r_out_opcode;
    assign o_final_fragment = r_out_fin;
    assign o_was_masked     = r_out_masked;
    assign o_frame_length   = r_out_len;
    assign o_first_of_frame = r_out_first;
    assign o_last_of_frame  = r_out_last;
    assign o_empty_frame    = r_out_empty;

    `WFD_ASSERT_NOW(a_empty_marker, r_out_valid && r_out_empty, r_out_first && r_out_last && (r_payload == 8'd0) && (r_out_len == 64'd0), "empty marker has wrong tags")
    `WFD_ASSERT_NOW(a_data_remaining, r_phase == PH_DATA, r_rem != 64'd0, "payload phase with no bytes remaining")
    `WFD_ASSERT_NEXT(a_result_held, r_out_valid && i_res_stall, r_out_valid && $stable(r_payload), "stalled result was lost")

endmodule
